@@ sv/mjd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum jumps package
// Shared types and constants for the minimum-jumps-to-end pass engine.
// ----------------------------------------------------------------------------
package mjd_pkg;

	localparam int MAX_PADS_DEF = 256;
	localparam int JUMP_W       = 16;
	localparam int MJ_W         = 9;
	localparam int SCORE_SAT    = 511;

	typedef struct packed {
		logic [JUMP_W-1:0] jump_length;
		logic              is_last;
	} pad_t;

	typedef struct packed {
		logic [MJ_W-1:0] min_jumps;
		logic            reachable;
		logic            overflow;
	} res_t;

	typedef struct packed {
		logic clr;
		logic take;
	} acc_ctrl_t;

endpackage

@@ sv/mjd_min_acc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window minimum accumulator
// Folds one score read per cycle into the least reachable score of a window.
// ----------------------------------------------------------------------------
module mjd_min_acc #(
	parameter int SW = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mjd_pkg::acc_ctrl_t  ctrl,
	input  logic                rd_reach,
	input  logic [SW-1:0]       rd_score,
	output logic                found,
	output logic [SW-1:0]       best
);
	import mjd_pkg::*;

	logic          found_q;
	logic [SW-1:0] best_q;
	logic          better;

	assign better = ctrl.take && rd_reach && (!found_q || (rd_score < best_q));
	assign found  = found_q || better;
	assign best   = better ? rd_score : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctrl.clr) begin
			found_q <= 1'b0;
		end else begin
			found_q <= found;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.take) begin
			best_q <= best;
		end
	end

endmodule

@@ sv/min_jumps_to_end_dp_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum jumps to end of a row of pads
// Loads a row of jump lengths into a pad memory, then runs a backward
// dynamic-programming pass through a score memory and reports pad 0.
// ----------------------------------------------------------------------------
// Channel  Signals                           Transfer
// pad      pad_valid, pad_ready, pad         one jump length per transfer
// res      res_valid, res_ready, res         one result per row
//
// Loading accepts one pad per cycle. After the last pad, the pass visits each
// pad from the end: a pad memory read and a decision, then, when the window
// must be scanned, score memory reads across the window and a drain step that
// writes the score; the single score read port sets the cost of a row.
// Reset clears the control state only; memories need no clearing.
// The result waits in an output register, so loading of the next row may
// begin while res_ready is low.
// ----------------------------------------------------------------------------
module min_jumps_to_end_dp_top #(
	parameter int MAX_PADS = mjd_pkg::MAX_PADS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pad_valid,
	output logic          pad_ready,
	input  mjd_pkg::pad_t pad,
	output logic          res_valid,
	input  logic          res_ready,
	output mjd_pkg::res_t res
);
	import mjd_pkg::*;

	localparam int AW = (MAX_PADS > 1) ? $clog2(MAX_PADS) : 1;
	localparam int CW = $clog2(MAX_PADS + 1);
	localparam int SW = AW;
	localparam int DW = (CW > JUMP_W) ? CW : JUMP_W;
	localparam int XW = (SW > MJ_W) ? SW : MJ_W;

	typedef enum logic [6:0] {
		ST_LOAD  = 7'b0000001,
		ST_START = 7'b0000010,
		ST_PREAD = 7'b0000100,
		ST_PEVAL = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DRAIN = 7'b0100000,
		ST_FIN   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [JUMP_W-1:0] pad_mem [MAX_PADS];
	logic [SW:0]       sc_mem  [MAX_PADS];

	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	logic [AW-1:0]     rem_q;
	logic [JUMP_W-1:0] pad_rd_q;
	logic [SW:0]       sc_rd_q;
	logic              vld_s1;
	logic              res_reach_q;
	logic [SW-1:0]     res_score_q;
	logic              out_valid_q;
	res_t              out_q;

	logic              pad_xfer;
	logic              pad_we;
	logic [CW-1:0]     tail_gap;
	logic              jump_zero;
	logic              jump_ends;
	logic              sc_we;
	logic [SW:0]       sc_wdata;
	logic              slot_free;
	logic              acc_found;
	logic [SW-1:0]     acc_best;
	acc_ctrl_t         acc_ctrl;
	logic [XW-1:0]     score_ext;

	assign pad_ready = (state_q == ST_LOAD);
	assign pad_xfer  = pad_valid && pad_ready;
	assign pad_we    = pad_xfer && (cnt_q < CW'(MAX_PADS));

	assign tail_gap  = cnt_q - CW'(1) - CW'(i_q);
	assign jump_zero = (pad_rd_q == '0);
	assign jump_ends = DW'(pad_rd_q) >= DW'(tail_gap);

	assign acc_ctrl.clr  = (state_q == ST_PEVAL);
	assign acc_ctrl.take = vld_s1;

	mjd_min_acc #(
		.SW(SW)
	) u_min_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (acc_ctrl),
		.rd_reach (sc_rd_q[SW]),
		.rd_score (sc_rd_q[SW-1:0]),
		.found    (acc_found),
		.best     (acc_best)
	);

	always_comb begin
		sc_we    = 1'b0;
		sc_wdata = '0;
		if (state_q == ST_PEVAL) begin
			if (jump_zero) begin
				sc_we = 1'b1;
			end else if (jump_ends) begin
				sc_we    = 1'b1;
				sc_wdata = {1'b1, SW'(1)};
			end
		end else if (state_q == ST_DRAIN) begin
			sc_we    = 1'b1;
			sc_wdata = acc_found ? {1'b1, acc_best + SW'(1)} : '0;
		end
	end

	assign slot_free = !out_valid_q || res_ready;
	assign score_ext = XW'(res_score_q);

	always_ff @(posedge clk) begin
		if (pad_we) begin
			pad_mem[cnt_q[AW-1:0]] <= pad.jump_length;
		end
		pad_rd_q <= pad_mem[i_q];
	end

	always_ff @(posedge clk) begin
		if (sc_we) begin
			sc_mem[i_q] <= sc_wdata;
		end
		sc_rd_q <= sc_mem[j_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			rem_q       <= '0;
			vld_s1      <= 1'b0;
			res_reach_q <= 1'b0;
			res_score_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_SCAN);
			if ((state_q == ST_FIN) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (sc_we && (i_q == '0)) begin
				res_reach_q <= sc_wdata[SW];
				res_score_q <= sc_wdata[SW-1:0];
			end
			unique case (state_q)
				ST_LOAD: begin
					if (pad_xfer) begin
						if (pad_we) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (pad.is_last) begin
							state_q <= ST_START;
						end
					end
				end
				ST_START: begin
					if (cnt_q <= CW'(1)) begin
						res_reach_q <= 1'b1;
						res_score_q <= SW'(1);
						state_q     <= ST_FIN;
					end else begin
						i_q     <= AW'(cnt_q - CW'(2));
						state_q <= ST_PREAD;
					end
				end
				ST_PREAD: begin
					state_q <= ST_PEVAL;
				end
				ST_PEVAL: begin
					if (jump_zero || jump_ends) begin
						if (i_q == '0) begin
							state_q <= ST_FIN;
						end else begin
							i_q     <= i_q - AW'(1);
							state_q <= ST_PREAD;
						end
					end else begin
						j_q     <= i_q + AW'(1);
						rem_q   <= pad_rd_q[AW-1:0];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					j_q   <= j_q + AW'(1);
					rem_q <= rem_q - AW'(1);
					if (rem_q == AW'(1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (i_q == '0) begin
						state_q <= ST_FIN;
					end else begin
						i_q     <= i_q - AW'(1);
						state_q <= ST_PREAD;
					end
				end
				ST_FIN: begin
					if (slot_free) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && slot_free) begin
			out_q.min_jumps <= (score_ext > XW'(SCORE_SAT)) ? MJ_W'(SCORE_SAT)
			                                                : score_ext[MJ_W-1:0];
			out_q.reachable <= res_reach_q;
			out_q.overflow  <= ovf_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.reachable || (res.min_jumps == '0)))
		else $error("unreachable result carries a nonzero jump count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_PADS))
		else $error("pad count exceeds the pad memory depth");

	a_scan_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ((CW'(j_q) < cnt_q - CW'(1)) && (j_q > i_q)))
		else $error("window scan reads outside the scored pads");

	a_fin_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FIN) && !slot_free) |=> (state_q == ST_FIN))
		else $error("result dropped while the output register was full");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Minimum jumps to end testbench
// Sends rows of pads to the minimum-jumps engine and predicts the fewest jumps
// from pad 0, the reach flag and the overflow flag of each row. Each result is
// checked against the prediction in order. Sender and receiver both pause at
// random, and one long receiver hold-off backs the engine up into its input.
// ----------------------------------------------------------------------------
module tb_top;
	import mjd_pkg::*;

	localparam int ROW_CAP   = MAX_PADS_DEF;
	localparam int ITEM_GOAL = 1800;
	localparam int TAIL_FROM = 1650;

	typedef enum int {
		SHAPE_MIXED,
		SHAPE_NOISE,
		SHAPE_CHAIN,
		SHAPE_ONES,
		SHAPE_WIDE
	} row_shape_e;

	class row_checker;
		logic [JUMP_W-1:0] row_jumps[$];
		bit                row_spilled;
		res_t              expected_results[$];
		int                mismatches;
		int                pads_noted;
		int                rows_checked;
		int                reach_rows;
		int                spill_rows;

		function res_t predict_min_jumps();
			res_t r;
			int   n;
			int   best;
			int   jl;
			bit   found;
			int   score[ROW_CAP];
			bit   reach[ROW_CAP];
			n = row_jumps.size();
			r = '0;
			r.overflow = row_spilled;
			if (n <= 1) begin
				r.min_jumps = MJ_W'(1);
				r.reachable = 1'b1;
				return r;
			end
			score[n-1] = 0;
			reach[n-1] = 1'b1;
			for (int i = n - 2; i >= 0; i--) begin
				jl = row_jumps[i];
				if (jl == 0) begin
					reach[i] = 1'b0;
					score[i] = 0;
				end else if (jl >= n - 1 - i) begin
					reach[i] = 1'b1;
					score[i] = 1;
				end else begin
					found = 1'b0;
					best = 0;
					for (int j = i + 1; j <= i + jl; j++) begin
						if (reach[j] && (!found || score[j] < best)) begin
							best = score[j];
							found = 1'b1;
						end
					end
					reach[i] = found;
					score[i] = found ? best + 1 : 0;
				end
			end
			best = reach[0] ? score[0] : 0;
			if (best > SCORE_SAT)
				best = SCORE_SAT;
			r.min_jumps = MJ_W'(best);
			r.reachable = reach[0];
			return r;
		endfunction

		function void note_pad(pad_t p);
			pads_noted++;
			if (row_jumps.size() < ROW_CAP)
				row_jumps = {row_jumps, p.jump_length};
			else
				row_spilled = 1'b1;
			if (p.is_last) begin
				expected_results = {expected_results, predict_min_jumps()};
				row_jumps.delete();
				row_spilled = 1'b0;
			end
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= 40)
				$display("tb_top: mismatch at %0t: %s", $realtime, what);
		endtask

		task check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				report($sformatf("result %p with no row pending", got));
				return;
			end
			want = expected_results.pop_front();
			rows_checked++;
			if (want.reachable)
				reach_rows++;
			if (want.overflow)
				spill_rows++;
			if (got.min_jumps !== want.min_jumps)
				report($sformatf("row %0d min_jumps %0d, predicted %0d",
					rows_checked, got.min_jumps, want.min_jumps));
			if (got.reachable !== want.reachable)
				report($sformatf("row %0d reachable %b, predicted %b",
					rows_checked, got.reachable, want.reachable));
			if (got.overflow !== want.overflow)
				report($sformatf("row %0d overflow %b, predicted %b",
					rows_checked, got.overflow, want.overflow));
		endtask

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pad_valid = 1'b0;
	logic pad_ready;
	pad_t pad = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_t res;

	row_checker        sb;
	logic [JUMP_W-1:0] row_q[$];
	int                items_sent;
	int                quiet_items;
	bit                tail_mode;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	min_jumps_to_end_dp_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pad_valid(pad_valid),
		.pad_ready(pad_ready),
		.pad      (pad),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	function automatic logic [JUMP_W-1:0] pick_jump(row_shape_e shape);
		int r;
		r = $urandom_range(0, 15);
		case (shape)
			SHAPE_ONES: return 16'd1;
			SHAPE_CHAIN: return 16'($urandom_range(1, 2));
			SHAPE_WIDE: return 16'($urandom_range(0, 300));
			SHAPE_NOISE: begin
				if (r < 4)
					return 16'd0;
				return 16'($urandom_range(0, 65535));
			end
			default: begin
				if (r == 0)
					return 16'd0;
				if (r == 1)
					return 16'($urandom_range(0, 65535));
				if (r == 2)
					return 16'($urandom_range(5, 20));
				return 16'($urandom_range(1, 4));
			end
		endcase
	endfunction

	task put_pad(pad_t p);
		pad <= p;
		pad_valid <= 1'b1;
		do
			@(posedge clk);
		while (!pad_ready);
		sb.note_pad(p);
		items_sent++;
		if (items_sent >= TAIL_FROM)
			tail_mode = 1'b1;
	endtask

	task send_row();
		pad_t p;
		for (int i = 0; i < row_q.size(); i++) begin
			if (quiet_items > 0) begin
				quiet_items--;
			end else if (!tail_mode && $urandom_range(0, 3) == 0) begin
				pad_valid <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else if ($urandom_range(0, 40) == 0) begin
				quiet_items = $urandom_range(20, 80);
			end
			p.jump_length = row_q[i];
			p.is_last = (i == row_q.size() - 1);
			put_pad(p);
		end
	endtask

	task fill_row(row_shape_e shape, int n);
		row_q.delete();
		repeat (n) row_q = {row_q, pick_jump(shape)};
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
	end

	initial begin
		int  stall_left;
		int  hold_left;
		int  ready_quiet;
		bit  held;
		stall_left = 0;
		hold_left = 0;
		ready_quiet = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (!held && sb != null && sb.rows_checked >= 30) begin
				held = 1'b1;
				hold_left = 3000;
				res_ready <= 1'b0;
			end else if (stall_left > 0 && !tail_mode) begin
				stall_left--;
				res_ready <= 1'b0;
			end else if (ready_quiet > 0 || tail_mode) begin
				if (ready_quiet > 0)
					ready_quiet--;
				res_ready <= 1'b1;
			end else if ($urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16) - 1;
				res_ready <= 1'b0;
			end else begin
				if ($urandom_range(0, 200) == 0)
					ready_quiet = $urandom_range(100, 400);
				res_ready <= 1'b1;
			end
		end
	end

	initial begin
		#40_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		int         row_idx;
		int         pick;
		row_shape_e shape;
		sb = new();
		items_sent = 0;
		quiet_items = 0;
		tail_mode = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-pad rows, stuck and unreachable rows, detours around a stuck pad.
		row_q = '{16'd0};                         send_row();
		row_q = '{16'hFFFF};                      send_row();
		row_q = '{16'd0, 16'd5};                  send_row();
		row_q = '{16'd1, 16'd0};                  send_row();
		row_q = '{16'd1, 16'd1, 16'd1, 16'd0};    send_row();
		row_q = '{16'd2, 16'd0, 16'd1, 16'd0};    send_row();
		row_q = '{16'd1, 16'd0, 16'd3};           send_row();
		row_q = '{16'hFFFF, 16'd0, 16'd0, 16'd0}; send_row();

		row_idx = 0;
		while (items_sent < ITEM_GOAL) begin
			if (row_idx == 2) begin
				fill_row(SHAPE_ONES, ROW_CAP);
			end else if (row_idx == 5 || row_idx == 60) begin
				fill_row(SHAPE_MIXED, ROW_CAP + $urandom_range(1, 20));
			end else if (row_idx == 9) begin
				fill_row(SHAPE_WIDE, ROW_CAP);
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < 8)
					fill_row(SHAPE_NOISE, 1);
				else if (pick < 70)
					fill_row(SHAPE_MIXED, $urandom_range(2, 12));
				else if (pick < 85)
					fill_row(SHAPE_MIXED, $urandom_range(13, 48));
				else if (pick < 92)
					fill_row(SHAPE_NOISE, $urandom_range(2, 24));
				else if (pick < 97)
					fill_row(SHAPE_CHAIN, $urandom_range(2, 40));
				else
					fill_row(SHAPE_MIXED, $urandom_range(200, ROW_CAP));
			end
			send_row();
			row_idx++;
		end
		pad_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("tb_top: %0d pads in %0d rows, %0d reachable, %0d with dropped pads",
			sb.pads_noted, sb.rows_checked, sb.reach_rows, sb.spill_rows);
		$display("tb_top: %0d mismatches", sb.mismatches);
		if (sb.mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule
